@@ design/dfsmz_pkg.sv @@
package dfsmz_pkg;

  localparam int MODE_W = 2;
  localparam int RND_W = 15;
  localparam int COORD_W = 6;
  localparam int WALL_W = 4;
  localparam int DIR_W = 2;
  localparam int CFG_INDEX_W = 4;
  localparam int CFG_DATA_W = 7;

  localparam logic [MODE_W-1:0] MODE_START = 2'd0;
  localparam logic [MODE_W-1:0] MODE_STEP = 2'd1;
  localparam logic [MODE_W-1:0] MODE_READ = 2'd2;

  localparam logic [CFG_INDEX_W-1:0] CFG_ROW_COUNT = 4'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_COL_COUNT = 4'd1;

  localparam logic [DIR_W-1:0] DIR_N = 2'd0;
  localparam logic [DIR_W-1:0] DIR_S = 2'd1;
  localparam logic [DIR_W-1:0] DIR_E = 2'd2;
  localparam logic [DIR_W-1:0] DIR_WEST = 2'd3;

  localparam logic [WALL_W-1:0] WALL_N = 4'd8;
  localparam logic [WALL_W-1:0] WALL_S = 4'd4;
  localparam logic [WALL_W-1:0] WALL_E = 4'd2;
  localparam logic [WALL_W-1:0] WALL_WEST = 4'd1;
  localparam logic [WALL_W-1:0] WALLS_ALL = 4'd15;
  localparam logic [WALL_W-1:0] WALLS_ENTRY = 4'd7;
  localparam logic [WALL_W-1:0] WALLS_EXIT = 4'd11;
  localparam logic [WALL_W-1:0] WALLS_SINGLE = 4'd3;

  localparam logic [CFG_DATA_W-1:0] GRID_RESET = 7'd64;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_INIT_LAST,
    ST_INIT_FIRST,
    ST_READ,
    ST_POP,
    ST_SCAN,
    ST_PICK,
    ST_THERE,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic [WALL_W-1:0]  walls;
    logic [COORD_W-1:0] cell_row;
    logic [COORD_W-1:0] cell_col;
    logic [DIR_W-1:0]   carved_dir;
    logic               carved;
    logic               finished;
  } result_t;

  function automatic logic [WALL_W-1:0] own_mask(input logic [DIR_W-1:0] dir);
    logic [WALL_W-1:0] m;
    case (dir)
      DIR_N: m = WALL_N;
      DIR_S: m = WALL_S;
      DIR_E: m = WALL_E;
      default: m = WALL_WEST;
    endcase
    return m;
  endfunction

  function automatic logic [WALL_W-1:0] far_mask(input logic [DIR_W-1:0] dir);
    logic [WALL_W-1:0] m;
    case (dir)
      DIR_N: m = WALL_S;
      DIR_S: m = WALL_N;
      DIR_E: m = WALL_WEST;
      default: m = WALL_E;
    endcase
    return m;
  endfunction

endpackage

@@ design/dfsmz_cfg_if.sv @@
interface dfsmz_cfg_if import dfsmz_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic [CFG_INDEX_W-1:0] index;
  logic [CFG_DATA_W-1:0]  data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

@@ design/dfsmz_cmd_if.sv @@
interface dfsmz_cmd_if import dfsmz_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [MODE_W-1:0]  mode;
  logic [RND_W-1:0]   random_value;
  logic [COORD_W-1:0] read_row;
  logic [COORD_W-1:0] read_col;

  modport source (output valid, output mode, output random_value, output read_row,
                  output read_col, input ready);
  modport sink (input valid, input mode, input random_value, input read_row,
                input read_col, output ready);
endinterface

@@ design/dfsmz_res_if.sv @@
interface dfsmz_res_if import dfsmz_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [WALL_W-1:0]  walls;
  logic [COORD_W-1:0] cell_row;
  logic [COORD_W-1:0] cell_col;
  logic [DIR_W-1:0]   carved_dir;
  logic               carved;
  logic               finished;

  modport source (output valid, output walls, output cell_row, output cell_col,
                  output carved_dir, output carved, output finished, input ready);
  modport sink (input valid, input walls, input cell_row, input cell_col,
                input carved_dir, input carved, input finished, output ready);
endinterface

@@ design/random_dfs_maze_carver_top.sv @@
// Channel  Dir  Handshake      Payload
// cfg      in   valid/ready    index, data (row_count = 0, col_count = 1)
// cmd      in   valid/ready    mode, random_value, read_row, read_col
// res      out  valid/ready    walls, cell_row, cell_col, carved_dir, carved, finished
//
// A carving step does one stack read, five reads of the cell memory (four
// neighbors and the current cell) through its single read port, and two
// wall writes. Reset and every start sweep the cell memory, one entry per
// cycle, and no command is taken meanwhile. A result waits in the output
// register, and a stalled output holds the next item in its last state.
module random_dfs_maze_carver_top import dfsmz_pkg::*; #(
  parameter int MAX_ROWS = 64,
  parameter int MAX_COLS = 64,
  parameter int RANDOM_RANGE = 32768
) (
  input logic       clk,
  input logic       rst,
  dfsmz_cfg_if.sink cfg,
  dfsmz_cmd_if.sink cmd,
  dfsmz_res_if.source res
);

  localparam int CELLS = MAX_ROWS * MAX_COLS;
  localparam int AW = (CELLS > 1) ? $clog2(CELLS) : 1;
  localparam int LW = $clog2(CELLS + 1);
  localparam int RW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int CW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int RCW = $clog2(MAX_ROWS + 1);
  localparam int CCW = $clog2(MAX_COLS + 1);
  localparam int SW = RW + CW;
  localparam int CELL_W = WALL_W + 1;
  localparam int Q2 = RANDOM_RANGE / 2;
  localparam int Q3 = RANDOM_RANGE / 3;
  localparam int Q4 = RANDOM_RANGE / 4;

  state_t state;
  state_t state_next;

  logic [CFG_DATA_W-1:0] row_count;
  logic [CFG_DATA_W-1:0] col_count;
  logic [RCW-1:0]        nr;
  logic [CCW-1:0]        nc;

  logic [AW-1:0]     clr_cnt;
  logic              clr_last;
  logic              start_pending;
  logic [LW-1:0]     level;
  logic [LW-1:0]     level_dec;
  logic [RND_W-1:0]  rnd_q;
  logic              in_grid_q;
  logic              rd_in_grid;
  logic [RW-1:0]     cr;
  logic [CW-1:0]     cc;
  logic [2:0]        scan_cnt;
  logic [2:0]        scan_prev;
  logic [CELL_W-1:0] nb_q [5];
  logic [RW-1:0]     pick_r;
  logic [CW-1:0]     pick_c;
  logic [AW-1:0]     pick_addr;
  logic [WALL_W-1:0] pick_walls;
  result_t           res_q;
  result_t           out_q;
  logic              out_valid;
  logic              out_free;

  logic [RW-1:0]     nb_r [4];
  logic [CW-1:0]     nb_c [4];
  logic [AW-1:0]     nb_addr [4];
  logic [3:0]        nb_in;
  logic [3:0]        nb_ok;
  logic [2:0]        nb_cnt;
  logic [1:0]        pick_idx;
  logic [DIR_W-1:0]  sel;
  logic [AW-1:0]     here_addr;
  logic [AW-1:0]     last_addr;
  logic              one_cell;

  logic              cell_we;
  logic [AW-1:0]     cell_waddr;
  logic [CELL_W-1:0] cell_wdata;
  logic [AW-1:0]     cell_raddr;
  logic [CELL_W-1:0] cell_rdata;
  logic              stk_we;
  logic [AW-1:0]     stk_waddr;
  logic [SW-1:0]     stk_wdata;
  logic [AW-1:0]     stk_raddr;
  logic [SW-1:0]     stk_rdata;

  logic cmd_acc;

  function automatic logic [AW-1:0] cell_addr(input logic [RW-1:0] r, input logic [CW-1:0] c);
    int a;
    a = int'(r) * MAX_COLS + int'(c);
    return AW'(a);
  endfunction

  dfsmz_ram #(.WIDTH(CELL_W), .DEPTH(CELLS)) u_cell_ram (
    .clk   (clk),
    .we    (cell_we),
    .waddr (cell_waddr),
    .wdata (cell_wdata),
    .raddr (cell_raddr),
    .rdata (cell_rdata)
  );

  dfsmz_ram #(.WIDTH(SW), .DEPTH(CELLS)) u_stack_ram (
    .clk   (clk),
    .we    (stk_we),
    .waddr (stk_waddr),
    .wdata (stk_wdata),
    .raddr (stk_raddr),
    .rdata (stk_rdata)
  );

  assign cfg.ready = 1'b1;
  assign cmd_acc = cmd.valid && cmd.ready;
  assign out_free = !out_valid || res.ready;
  assign clr_last = (clr_cnt == AW'(CELLS - 1));
  assign level_dec = level - LW'(1);
  assign scan_prev = scan_cnt - 3'd1;

  always_comb begin
    if (row_count == '0) begin
      nr = RCW'(1);
    end else if (int'(row_count) > MAX_ROWS) begin
      nr = RCW'(MAX_ROWS);
    end else begin
      nr = RCW'(row_count);
    end
    if (col_count == '0) begin
      nc = CCW'(1);
    end else if (int'(col_count) > MAX_COLS) begin
      nc = CCW'(MAX_COLS);
    end else begin
      nc = CCW'(col_count);
    end
  end

  assign one_cell = (nr == RCW'(1)) && (nc == CCW'(1));
  assign last_addr = cell_addr(RW'(nr - RCW'(1)), CW'(nc - CCW'(1)));
  assign here_addr = cell_addr(cr, cc);
  assign rd_in_grid = (int'(cmd.read_row) < int'(nr)) && (int'(cmd.read_col) < int'(nc));

  always_comb begin
    nb_r[0] = cr - RW'(1);
    nb_c[0] = cc;
    nb_r[1] = cr + RW'(1);
    nb_c[1] = cc;
    nb_r[2] = cr;
    nb_c[2] = cc + CW'(1);
    nb_r[3] = cr;
    nb_c[3] = cc - CW'(1);
    for (int k = 0; k < 4; k++) begin
      nb_addr[k] = cell_addr(nb_r[k], nb_c[k]);
    end
    nb_in[0] = (int'(cr) >= 1) && (int'(cr) - 1 < int'(nr)) && (int'(cc) < int'(nc));
    nb_in[1] = (int'(cr) + 1 < int'(nr)) && (int'(cc) < int'(nc));
    nb_in[2] = (int'(cr) < int'(nr)) && (int'(cc) + 1 < int'(nc));
    nb_in[3] = (int'(cr) < int'(nr)) && (int'(cc) >= 1) && (int'(cc) - 1 < int'(nc));
    for (int k = 0; k < 4; k++) begin
      nb_ok[k] = nb_in[k] && !nb_q[k][WALL_W];
    end
  end

  assign nb_cnt = 3'(nb_ok[0]) + 3'(nb_ok[1]) + 3'(nb_ok[2]) + 3'(nb_ok[3]);

  // The pick index is the number of thresholds k * (RANDOM_RANGE / n) that the
  // random word reaches, which is the quotient already clamped to n - 1.
  always_comb begin
    pick_idx = 2'd0;
    case (nb_cnt)
      3'd2: begin
        if (int'(rnd_q) >= Q2) pick_idx = 2'd1;
      end
      3'd3: begin
        if (int'(rnd_q) >= 2 * Q3) begin
          pick_idx = 2'd2;
        end else if (int'(rnd_q) >= Q3) begin
          pick_idx = 2'd1;
        end
      end
      3'd4: begin
        if (int'(rnd_q) >= 3 * Q4) begin
          pick_idx = 2'd3;
        end else if (int'(rnd_q) >= 2 * Q4) begin
          pick_idx = 2'd2;
        end else if (int'(rnd_q) >= Q4) begin
          pick_idx = 2'd1;
        end
      end
      default: pick_idx = 2'd0;
    endcase
  end

  always_comb begin
    logic [1:0] seen;
    seen = 2'd0;
    sel = DIR_N;
    for (int k = 0; k < 4; k++) begin
      if (nb_ok[k]) begin
        if (seen == pick_idx) sel = DIR_W'(k);
        seen = seen + 2'd1;
      end
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: begin
        if (clr_last) state_next = start_pending ? ST_INIT_LAST : ST_IDLE;
      end
      ST_IDLE: begin
        if (cmd_acc) begin
          case (cmd.mode)
            MODE_START: state_next = ST_CLEAR;
            MODE_READ: state_next = ST_READ;
            MODE_STEP: state_next = (level == '0) ? ST_OUT : ST_POP;
            default: state_next = ST_OUT;
          endcase
        end
      end
      ST_INIT_LAST: state_next = ST_INIT_FIRST;
      ST_INIT_FIRST: state_next = ST_OUT;
      ST_READ: state_next = ST_OUT;
      ST_POP: state_next = ST_SCAN;
      ST_SCAN: begin
        if (scan_cnt == 3'd5) state_next = ST_PICK;
      end
      ST_PICK: state_next = (nb_ok != '0) ? ST_THERE : ST_OUT;
      ST_THERE: state_next = ST_OUT;
      ST_OUT: begin
        if (out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd.ready = 1'b0;
    cell_we = 1'b0;
    cell_waddr = here_addr;
    cell_wdata = {1'b0, WALLS_ALL};
    cell_raddr = here_addr;
    stk_we = 1'b0;
    stk_waddr = level[AW-1:0];
    stk_wdata = {pick_r, pick_c};
    stk_raddr = level_dec[AW-1:0];
    case (state)
      ST_CLEAR: begin
        cell_we = 1'b1;
        cell_waddr = clr_cnt;
      end
      ST_IDLE: begin
        cmd.ready = 1'b1;
        cell_raddr = cell_addr(RW'(cmd.read_row), CW'(cmd.read_col));
      end
      ST_INIT_LAST: begin
        cell_we = 1'b1;
        cell_waddr = last_addr;
        cell_wdata = {1'b0, WALLS_EXIT};
      end
      ST_INIT_FIRST: begin
        cell_we = 1'b1;
        cell_waddr = '0;
        cell_wdata = {1'b1, one_cell ? WALLS_SINGLE : WALLS_ENTRY};
        stk_we = 1'b1;
        stk_waddr = '0;
        stk_wdata = '0;
      end
      ST_SCAN: begin
        case (scan_cnt)
          3'd0: cell_raddr = nb_addr[0];
          3'd1: cell_raddr = nb_addr[1];
          3'd2: cell_raddr = nb_addr[2];
          3'd3: cell_raddr = nb_addr[3];
          default: cell_raddr = here_addr;
        endcase
      end
      ST_PICK: begin
        cell_we = (nb_ok != '0);
        cell_waddr = here_addr;
        cell_wdata = {nb_q[4][WALL_W], nb_q[4][WALL_W-1:0] & ~own_mask(sel)};
      end
      ST_THERE: begin
        cell_we = 1'b1;
        cell_waddr = pick_addr;
        cell_wdata = {1'b1, pick_walls & ~far_mask(res_q.carved_dir)};
        // The popped cell still sits at the top entry, so the neighbor goes above it.
        stk_we = 1'b1;
        stk_waddr = AW'(level + LW'(1));
      end
      default: begin
        cmd.ready = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
      clr_cnt <= '0;
      start_pending <= 1'b0;
      level <= '0;
      out_valid <= 1'b0;
      row_count <= GRID_RESET;
      col_count <= GRID_RESET;
    end else begin
      state <= state_next;
      if (cfg.valid && cfg.ready) begin
        if (cfg.index == CFG_ROW_COUNT) row_count <= cfg.data;
        if (cfg.index == CFG_COL_COUNT) col_count <= cfg.data;
      end
      if (state == ST_OUT && out_free) begin
        out_valid <= 1'b1;
      end else if (res.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_CLEAR: begin
          clr_cnt <= clr_last ? '0 : clr_cnt + AW'(1);
        end
        ST_IDLE: begin
          if (cmd_acc && cmd.mode == MODE_START) begin
            start_pending <= 1'b1;
            level <= '0;
          end
        end
        ST_INIT_FIRST: begin
          start_pending <= 1'b0;
          level <= LW'(1);
        end
        ST_POP: begin
          level <= level_dec;
        end
        ST_THERE: begin
          level <= level + LW'(2);
        end
        default: begin
          level <= level;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (cmd_acc) begin
          rnd_q <= cmd.random_value;
          in_grid_q <= rd_in_grid;
          res_q <= '{walls: '0, cell_row: '0, cell_col: '0, carved_dir: '0, carved: 1'b0,
                     finished: (cmd.mode == MODE_STEP) && (level == '0)};
        end
      end
      ST_READ: begin
        res_q.walls <= in_grid_q ? cell_rdata[WALL_W-1:0] : '0;
      end
      ST_POP: begin
        cr <= stk_rdata[SW-1:CW];
        cc <= stk_rdata[CW-1:0];
        scan_cnt <= 3'd0;
      end
      ST_SCAN: begin
        scan_cnt <= scan_cnt + 3'd1;
        if (scan_cnt != 3'd0) nb_q[scan_prev] <= cell_rdata;
      end
      ST_PICK: begin
        if (nb_ok != '0) begin
          res_q.cell_row <= COORD_W'(cr);
          res_q.cell_col <= COORD_W'(cc);
          res_q.carved_dir <= sel;
          res_q.carved <= 1'b1;
          pick_r <= nb_r[sel];
          pick_c <= nb_c[sel];
          pick_addr <= nb_addr[sel];
          pick_walls <= nb_q[{1'b0, sel}][WALL_W-1:0];
        end
      end
      ST_OUT: begin
        if (out_free) out_q <= res_q;
      end
      default: begin
        res_q <= res_q;
      end
    endcase
  end

  assign res.valid = out_valid;
  assign res.walls = out_q.walls;
  assign res.cell_row = out_q.cell_row;
  assign res.cell_col = out_q.cell_col;
  assign res.carved_dir = out_q.carved_dir;
  assign res.carved = out_q.carved;
  assign res.finished = out_q.finished;

endmodule

@@ design/dfsmz_ram.sv @@
module dfsmz_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ tb/sv/random_dfs_maze_carver_top_tb.sv @@
`timescale 1ns / 100ps

module random_dfs_maze_carver_top_tb import dfsmz_pkg::*; ();

  localparam int GRID_ROWS = 64;
  localparam int GRID_COLS = 64;
  localparam int RAND_SPAN = 32768;
  localparam int CELLS = GRID_ROWS * GRID_COLS;
  localparam int SWEEP_WAIT = CELLS + 64;
  localparam int QUIET_LIMIT = 50000;
  localparam int RANDOM_PHASES = 8;
  localparam int PHASE_ITEMS = 100;
  localparam int HEADING_W = 2;
  localparam logic [MODE_W-1:0] MODE_IGNORED = 2'd3;
  localparam logic [CFG_INDEX_W-1:0] CFG_SPARE = 4'd15;

  typedef struct {
    logic [MODE_W-1:0]  mode;
    logic [RND_W-1:0]   rnd;
    logic [COORD_W-1:0] row;
    logic [COORD_W-1:0] col;
    bit                 hold;
  } maze_cmd_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  dfsmz_cfg_if cfg_bus ();
  dfsmz_cmd_if cmd_bus ();
  dfsmz_res_if res_bus ();

  random_dfs_maze_carver_top #(
    .MAX_ROWS(GRID_ROWS),
    .MAX_COLS(GRID_COLS),
    .RANDOM_RANGE(RAND_SPAN)
  ) u_dut (
    .clk(clk),
    .rst(rst),
    .cfg(cfg_bus),
    .cmd(cmd_bus),
    .res(res_bus)
  );

  always #10 clk = ~clk;

  maze_cmd_t pending_cmds[$];
  result_t expected_results[$];

  logic [WALL_W-1:0] cell_walls [CELLS];
  bit seen_cell [CELLS];
  logic [2*COORD_W-1:0] trail [CELLS];
  int trail_depth;
  logic [CFG_DATA_W-1:0] row_setting;
  logic [CFG_DATA_W-1:0] col_setting;

  int send_idle_pct;
  int stall_pct;
  int error_count;
  int quiet_cycles;
  bit cmd_taken;
  result_t got_res;
  result_t want_res;

  function automatic int grid_span(input int setting, input int limit);
    if (setting == 0) return 1;
    if (setting > limit) return limit;
    return setting;
  endfunction

  function automatic void trail_push(input int r, input int c);
    if (trail_depth < CELLS) begin
      trail[trail_depth] = {r[COORD_W-1:0], c[COORD_W-1:0]};
      trail_depth++;
    end
  endfunction

  function automatic result_t next_maze_result(input logic [MODE_W-1:0] mode,
                                               input logic [RND_W-1:0] rnd,
                                               input logic [COORD_W-1:0] rr,
                                               input logic [COORD_W-1:0] rc);
    result_t r;
    int nr, nc, cr, cc, n, q, idx, here, there;
    int nb_r[4];
    int nb_c[4];
    logic [HEADING_W-1:0] nb_d[4];
    r = '0;
    nr = grid_span(int'(row_setting), GRID_ROWS);
    nc = grid_span(int'(col_setting), GRID_COLS);
    case (mode)
      MODE_START: begin
        for (int i = 0; i < CELLS; i++) begin
          cell_walls[i] = WALLS_ALL;
          seen_cell[i] = 1'b0;
        end
        cell_walls[0] = WALLS_ENTRY;
        cell_walls[(nr - 1) * GRID_COLS + nc - 1] = WALLS_EXIT;
        if (nr == 1 && nc == 1) cell_walls[0] = WALLS_SINGLE;
        trail_depth = 0;
        seen_cell[0] = 1'b1;
        trail_push(0, 0);
      end
      MODE_READ: begin
        if (int'(rr) < nr && int'(rc) < nc) r.walls = cell_walls[int'(rr) * GRID_COLS + int'(rc)];
      end
      MODE_STEP: begin
        if (trail_depth == 0) begin
          r.finished = 1'b1;
        end else begin
          trail_depth--;
          cr = int'(trail[trail_depth][2*COORD_W-1:COORD_W]);
          cc = int'(trail[trail_depth][COORD_W-1:0]);
          n = 0;
          if (cr >= 1 && cr - 1 < nr && cc < nc && !seen_cell[(cr - 1) * GRID_COLS + cc]) begin
            nb_r[n] = cr - 1; nb_c[n] = cc; nb_d[n] = DIR_N; n++;
          end
          if (cr + 1 < nr && cc < nc && !seen_cell[(cr + 1) * GRID_COLS + cc]) begin
            nb_r[n] = cr + 1; nb_c[n] = cc; nb_d[n] = DIR_S; n++;
          end
          if (cr < nr && cc + 1 < nc && !seen_cell[cr * GRID_COLS + cc + 1]) begin
            nb_r[n] = cr; nb_c[n] = cc + 1; nb_d[n] = DIR_E; n++;
          end
          if (cr < nr && cc >= 1 && cc - 1 < nc && !seen_cell[cr * GRID_COLS + cc - 1]) begin
            nb_r[n] = cr; nb_c[n] = cc - 1; nb_d[n] = DIR_WEST; n++;
          end
          if (n != 0) begin
            trail_push(cr, cc);
            q = RAND_SPAN / n;
            idx = (q == 0) ? n - 1 : int'(rnd) / q;
            if (idx > n - 1) idx = n - 1;
            here = cr * GRID_COLS + cc;
            there = nb_r[idx] * GRID_COLS + nb_c[idx];
            case (nb_d[idx])
              DIR_N: begin
                cell_walls[here] &= ~WALL_N;
                cell_walls[there] &= ~WALL_S;
              end
              DIR_S: begin
                cell_walls[here] &= ~WALL_S;
                cell_walls[there] &= ~WALL_N;
              end
              DIR_E: begin
                cell_walls[here] &= ~WALL_E;
                cell_walls[there] &= ~WALL_WEST;
              end
              default: begin
                cell_walls[here] &= ~WALL_WEST;
                cell_walls[there] &= ~WALL_E;
              end
            endcase
            seen_cell[there] = 1'b1;
            trail_push(nb_r[idx], nb_c[idx]);
            r.cell_row = cr[COORD_W-1:0];
            r.cell_col = cc[COORD_W-1:0];
            r.carved_dir = nb_d[idx];
            r.carved = 1'b1;
          end
        end
      end
      default: begin
      end
    endcase
    return r;
  endfunction

  function automatic int random_grid_setting();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel < 7) return $urandom_range(1, 8);
    if (sel == 7) return $urandom_range(9, 64);
    if (sel == 8) return 0;
    return $urandom_range(65, 127);
  endfunction

  task automatic add_cmd(input logic [MODE_W-1:0] mode, input int rnd, input int row,
                         input int col, input bit hold = 1'b0);
    maze_cmd_t item;
    item.mode = mode;
    item.rnd = rnd[RND_W-1:0];
    item.row = row[COORD_W-1:0];
    item.col = col[COORD_W-1:0];
    item.hold = hold;
    pending_cmds = {pending_cmds, item};
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input int value);
    @(negedge clk);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data <= CFG_DATA_W'(value);
    @(posedge clk);
    while (!cfg_bus.ready) @(posedge clk);
    if (idx == CFG_ROW_COUNT) row_setting = CFG_DATA_W'(value);
    else if (idx == CFG_COL_COUNT) col_setting = CFG_DATA_W'(value);
    @(negedge clk);
    cfg_bus.valid <= 1'b0;
  endtask

  task automatic wait_drained();
    while (pending_cmds.size() != 0 || expected_results.size() != 0 || cmd_bus.valid)
      @(posedge clk);
  endtask

  always @(negedge clk) begin
    if (rst) begin
      cmd_bus.valid <= 1'b0;
    end else if (cmd_bus.valid && !cmd_taken) begin
    end else if (pending_cmds.size() != 0 && $urandom_range(0, 99) >= send_idle_pct &&
                 (!pending_cmds[0].hold || expected_results.size() == 0)) begin
      cmd_bus.valid <= 1'b1;
      cmd_bus.mode <= pending_cmds[0].mode;
      cmd_bus.random_value <= pending_cmds[0].rnd;
      cmd_bus.read_row <= pending_cmds[0].row;
      cmd_bus.read_col <= pending_cmds[0].col;
    end else begin
      cmd_bus.valid <= 1'b0;
    end
    cmd_taken = 1'b0;
  end

  always @(negedge clk) begin
    res_bus.ready <= ($urandom_range(0, 99) >= stall_pct);
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (res_bus.valid && res_bus.ready) begin
        got_res.walls = res_bus.walls;
        got_res.cell_row = res_bus.cell_row;
        got_res.cell_col = res_bus.cell_col;
        got_res.carved_dir = res_bus.carved_dir;
        got_res.carved = res_bus.carved;
        got_res.finished = res_bus.finished;
        if (expected_results.size() == 0) begin
          error_count++;
          if (error_count <= 10) $display("unexpected result item: %h", got_res);
        end else begin
          want_res = expected_results.pop_front();
          if (got_res.walls !== want_res.walls || got_res.cell_row !== want_res.cell_row ||
              got_res.cell_col !== want_res.cell_col ||
              got_res.carved_dir !== want_res.carved_dir ||
              got_res.carved !== want_res.carved || got_res.finished !== want_res.finished)
          begin
            error_count++;
            if (error_count <= 10) begin
              $display("mismatch: exp w=%0d r=%0d c=%0d d=%0d cv=%0b f=%0b",
                       want_res.walls, want_res.cell_row, want_res.cell_col,
                       want_res.carved_dir, want_res.carved, want_res.finished);
              $display("          got w=%0d r=%0d c=%0d d=%0d cv=%0b f=%0b",
                       got_res.walls, got_res.cell_row, got_res.cell_col,
                       got_res.carved_dir, got_res.carved, got_res.finished);
            end
          end
        end
      end
      if (cmd_bus.valid && cmd_bus.ready) begin
        expected_results = {expected_results,
                            next_maze_result(cmd_bus.mode, cmd_bus.random_value,
                                             cmd_bus.read_row, cmd_bus.read_col)};
        void'(pending_cmds.pop_front());
        cmd_taken = 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (cmd_bus.valid && cmd_bus.ready) || (res_bus.valid && res_bus.ready) ||
        (cfg_bus.valid && cfg_bus.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int count, sel, rnd;
    cfg_bus.valid = 1'b0;
    cfg_bus.index = '0;
    cfg_bus.data = '0;
    cmd_bus.valid = 1'b0;
    cmd_bus.mode = MODE_START;
    cmd_bus.random_value = '0;
    cmd_bus.read_row = '0;
    cmd_bus.read_col = '0;
    res_bus.ready = 1'b0;
    send_idle_pct = 0;
    stall_pct = 0;
    error_count = 0;
    quiet_cycles = 0;
    cmd_taken = 1'b0;
    trail_depth = 0;
    row_setting = GRID_RESET;
    col_setting = GRID_RESET;
    for (int i = 0; i < CELLS; i++) begin
      cell_walls[i] = WALLS_ALL;
      seen_cell[i] = 1'b0;
      trail[i] = '0;
    end
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    add_cmd(MODE_STEP, 0, 0, 0);
    add_cmd(MODE_READ, 0, 63, 63);
    add_cmd(MODE_IGNORED, 32767, 63, 63);
    add_cmd(MODE_START, 0, 0, 0);
    add_cmd(MODE_READ, 0, 0, 0);
    add_cmd(MODE_READ, 0, 63, 63);
    add_cmd(MODE_STEP, 0, 0, 0);
    add_cmd(MODE_STEP, 32767, 0, 0);
    add_cmd(MODE_READ, 0, 0, 0);
    add_cmd(MODE_READ, 0, 1, 0);
    wait_drained();
    repeat (SWEEP_WAIT) @(posedge clk);

    write_reg(CFG_ROW_COUNT, 0);
    write_reg(CFG_COL_COUNT, 0);
    add_cmd(MODE_START, 0, 0, 0);
    add_cmd(MODE_READ, 0, 0, 0);
    add_cmd(MODE_READ, 0, 0, 1);
    add_cmd(MODE_STEP, 12345, 0, 0);
    add_cmd(MODE_STEP, 12345, 0, 0);
    wait_drained();
    repeat (SWEEP_WAIT) @(posedge clk);

    // On a 3x3 grid this path reaches the center with three open neighbors.
    write_reg(CFG_ROW_COUNT, 3);
    write_reg(CFG_COL_COUNT, 3);
    write_reg(CFG_SPARE, 127);
    add_cmd(MODE_START, 0, 0, 0);
    add_cmd(MODE_STEP, 32767, 0, 0);
    add_cmd(MODE_STEP, 0, 0, 0);
    add_cmd(MODE_STEP, 32767, 0, 0);
    add_cmd(MODE_READ, 0, 1, 1);
    add_cmd(MODE_READ, 0, 1, 0);
    wait_drained();
    repeat (SWEEP_WAIT) @(posedge clk);

    write_reg(CFG_ROW_COUNT, 127);
    write_reg(CFG_COL_COUNT, 65);
    add_cmd(MODE_STEP, 21000, 0, 0);
    add_cmd(MODE_STEP, 5, 0, 0);
    add_cmd(MODE_READ, 0, 63, 63);

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      wait_drained();
      repeat (SWEEP_WAIT) @(posedge clk);
      write_reg(CFG_ROW_COUNT, random_grid_setting());
      write_reg(CFG_COL_COUNT, random_grid_setting());
      case (p % 4)
        0: begin send_idle_pct = 0; stall_pct = 0; end
        1: begin send_idle_pct = 53; stall_pct = 0; end
        2: begin send_idle_pct = 0; stall_pct = 53; end
        default: begin send_idle_pct = 10; stall_pct = 10; end
      endcase
      if ($urandom_range(0, 3) != 0) add_cmd(MODE_START, 0, 0, 0);
      count = 0;
      while (count < PHASE_ITEMS) begin
        sel = $urandom_range(0, 99);
        rnd = $urandom_range(0, 9);
        if (rnd == 0) rnd = 0;
        else if (rnd == 1) rnd = 32767;
        else rnd = $urandom_range(0, 32767);
        if (sel < 2) begin
          add_cmd(MODE_IGNORED, rnd, $urandom_range(0, 63), $urandom_range(0, 63));
        end else begin
          if (sel < 6) begin
            add_cmd(MODE_START, rnd, 0, 0, count == PHASE_ITEMS / 2);
          end else if (sel < 26) begin
            if ($urandom_range(0, 9) == 0)
              add_cmd(MODE_READ, rnd, $urandom_range(0, 63), $urandom_range(0, 63),
                      count == PHASE_ITEMS / 2);
            else
              add_cmd(MODE_READ, rnd, $urandom_range(0, 9), $urandom_range(0, 9),
                      count == PHASE_ITEMS / 2);
          end else begin
            add_cmd(MODE_STEP, rnd, $urandom_range(0, 63), $urandom_range(0, 63),
                    count == PHASE_ITEMS / 2);
          end
          count++;
        end
      end
    end

    wait_drained();
    repeat (64) @(posedge clk);
    if (error_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
